@@ rtl/ishi_pkg.sv @@
// Shared types, codes and helpers for the IMU sample history interpolator.
// No dependencies; every other file imports this package.
package ishi_pkg;

  localparam int NCOMP     = 6;
  localparam int VAL_W     = 32;
  localparam int TIME_W    = 64;
  localparam int VEC_W     = NCOMP * VAL_W;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int MAG_W     = VAL_W + 1;
  localparam int STEP_W    = 6;
  localparam int COMP_W    = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd1;

  localparam logic [LIM_W-1:0] RATE_LIMIT_RST  = 31'd983040;
  localparam logic [LIM_W-1:0] ACCEL_LIMIT_RST = 31'd5242880;

  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [VEC_W-1:0]  vec_t;

  typedef struct packed {
    stamp_t stamp;
    vec_t   vals;
  } entry_t;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    stamp_t                  dt;
    stamp_t                  span;
  } lerp_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } lerp_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_POST,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_Q_EMIT,
    ST_Q_LAST,
    ST_Q_K,
    ST_Q_A,
    ST_LERP_GO,
    ST_LERP_WAIT
  } state_t;

  function automatic logic [VAL_W-1:0] clamp_comp(input logic [VAL_W-1:0] x,
                                                  input logic [LIM_W-1:0] lim);
    logic signed [VAL_W:0] xe;
    logic signed [VAL_W:0] le;
    logic signed [VAL_W:0] r;
    xe = {x[VAL_W-1], x};
    le = {2'b00, lim};
    r  = xe;
    if (xe > le) begin
      r = le;
    end else if (xe < -le) begin
      r = -le;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/ishi_mem.sv @@
// History storage: one synchronous RAM holding time stamp and six components.
// One write port, one read port with registered data. Uses ishi_pkg.
module ishi_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ishi_pkg::entry_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output ishi_pkg::entry_t  rdata
);
  import ishi_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ishi_lerp.sv @@
// Serial interpolation unit: a +/- floor(|b - a| * dt / span), one digit a cycle.
// Busy from start until the last digit is in; done then pulses. Uses ishi_pkg.
module ishi_lerp (
  input  logic                clk,
  input  logic                rst_n,
  input  ishi_pkg::lerp_req_t req,
  output ishi_pkg::lerp_rsp_t rsp
);
  import ishi_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [STEP_W-1:0]       step_r;
  logic [MAG_W-1:0]        mag_r;
  logic [MAG_W-1:0]        quo_r;
  stamp_t                  rem_r;
  stamp_t                  dt_r;
  stamp_t                  span_r;
  logic                    neg_r;
  logic [VAL_W-1:0]        a_r;

  logic signed [MAG_W-1:0] diff;
  logic [TIME_W+1:0]       sum;
  logic [TIME_W+1:0]       one_span;
  logic [TIME_W+1:0]       two_span;
  logic [TIME_W+1:0]       rem_full;
  logic [1:0]              digit;

  assign diff     = MAG_W'(req.b) - MAG_W'(req.a);
  assign one_span = {2'b00, span_r};
  assign two_span = {1'b0, span_r, 1'b0};
  assign sum      = {1'b0, rem_r, 1'b0} + ({2'b00, dt_r} & {(TIME_W+2){mag_r[MAG_W-1]}});

  always_comb begin
    if (sum >= two_span) begin
      digit    = 2'd2;
      rem_full = sum - two_span;
    end else if (sum >= one_span) begin
      digit    = 2'd1;
      rem_full = sum - one_span;
    end else begin
      digit    = 2'd0;
      rem_full = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == STEP_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(MAG_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r  <= diff[MAG_W-1];
      mag_r  <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      quo_r  <= '0;
      rem_r  <= '0;
      dt_r   <= req.dt;
      span_r <= req.span;
      a_r    <= req.a;
    end else if (busy_r) begin
      mag_r <= {mag_r[MAG_W-2:0], 1'b0};
      quo_r <= {quo_r[MAG_W-2:0], 1'b0} + MAG_W'(digit);
      rem_r <= rem_full[TIME_W-1:0];
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = neg_r ? (a_r - quo_r[VAL_W-1:0]) : (a_r + quo_r[VAL_W-1:0]);

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("lerp started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("lerp done longer than one cycle");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("lerp done without work");
`endif

endmodule

@@ rtl/imu_sample_history_interpolator_unit.sv @@
// Top level of the IMU sample history interpolator: control sequencer, limits,
// result registers. Instantiates ishi_mem and ishi_lerp; uses ishi_pkg.
//
// Usage:
//   Input transaction: drive in_* and raise start; it is taken on an edge with
//   busy low. in_opcode 0 inserts a sample (no result), 1 queries a time.
//   Result: out_valid is high for exactly one cycle with the out_* values; the
//   receiver cannot stall, so it must take them in that cycle.
//   Configuration: cfg_valid with cfg_index/cfg_wdata; cfg_ready is always high.
//   Write limits only while busy is low.
// Timing:
//   A binary search over the stored entries takes a read and a compare state
//   per step. An insert then shifts the entries after (or, when full, before)
//   its slot through the single RAM port pair, alternating read and write
//   states per entry. A query then reads its neighbouring entries, or, when it
//   falls between two entries, runs 6 serial interpolations (the divider loop).
//   A query on an empty history answers in the next cycle.
// Reset: history empties and limits return to 15.0 and 80.0; RAM is not cleared.
module imu_sample_history_interpolator_unit #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [ishi_pkg::TIME_W-1:0]         in_time_stamp,
  input  logic signed [ishi_pkg::VAL_W-1:0]   in_rate_x_in,
  input  logic signed [ishi_pkg::VAL_W-1:0]   in_rate_y_in,
  input  logic signed [ishi_pkg::VAL_W-1:0]   in_rate_z_in,
  input  logic signed [ishi_pkg::VAL_W-1:0]   in_accel_x_in,
  input  logic signed [ishi_pkg::VAL_W-1:0]   in_accel_y_in,
  input  logic signed [ishi_pkg::VAL_W-1:0]   in_accel_z_in,
  input  logic [ishi_pkg::NCOMP-1:0]          in_invalid_mask,
  output logic                                out_valid,
  output logic signed [ishi_pkg::VAL_W-1:0]   out_rate_x_out,
  output logic signed [ishi_pkg::VAL_W-1:0]   out_rate_y_out,
  output logic signed [ishi_pkg::VAL_W-1:0]   out_rate_z_out,
  output logic signed [ishi_pkg::VAL_W-1:0]   out_accel_x_out,
  output logic signed [ishi_pkg::VAL_W-1:0]   out_accel_y_out,
  output logic signed [ishi_pkg::VAL_W-1:0]   out_accel_z_out,
  output logic                                out_history_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ishi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ishi_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import ishi_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     dst_r, dst_nxt;
  logic [CW-1:0]     tgt_r, tgt_nxt;
  logic              up_r, up_nxt;
  logic              op_r, op_nxt;
  stamp_t            t_r, t_nxt;
  vec_t              newv_r, newv_nxt;
  vec_t              a_vals_r, a_vals_nxt;
  vec_t              b_vals_r, b_vals_nxt;
  vec_t              res_r, res_nxt;
  stamp_t            dt_r, dt_nxt;
  stamp_t            span_r, span_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic [LIM_W-1:0]  rate_lim_r, accel_lim_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_empty_r, out_empty_nxt;
  vec_t              out_vals_r, out_vals_nxt;

  logic              accept;
  logic              hit;
  logic [CW:0]       mid_sum;
  logic [CW-1:0]     src;
  vec_t              in_vec;
  vec_t              clamped;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;
  lerp_req_t         lreq;
  lerp_rsp_t         lrsp;

  ishi_mem #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ishi_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lreq),
    .rsp   (lrsp)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign in_vec    = {in_accel_z_in, in_accel_y_in, in_accel_x_in,
                      in_rate_z_in, in_rate_y_in, in_rate_x_in};
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign hit       = (op_r == OP_QUERY) ? (mem_rdata.stamp >= t_r) : (mem_rdata.stamp > t_r);
  assign src       = up_r ? (dst_r - CW'(1)) : (dst_r + CW'(1));

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      clamped[i*VAL_W +: VAL_W] = clamp_comp(
        in_invalid_mask[i] ? '0 : in_vec[i*VAL_W +: VAL_W],
        (i < NCOMP / 2) ? rate_lim_r : accel_lim_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !(in_opcode == OP_QUERY && count_r == '0)) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH:     state_nxt = (lo_r < hi_r) ? ST_SRCH_CMP : ST_POST;
      ST_SRCH_CMP: state_nxt = ST_SRCH;
      ST_POST: begin
        if (op_r == OP_QUERY) begin
          state_nxt = (lo_r == '0) ? ST_Q_EMIT : ST_Q_LAST;
        end else if (count_r < CW'(HISTORY_DEPTH) || lo_r != '0) begin
          state_nxt = ST_SH_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SH_RD:  state_nxt = (dst_r == tgt_r) ? ST_INS_WR : ST_SH_WR;
      ST_SH_WR:  state_nxt = ST_SH_RD;
      ST_INS_WR: state_nxt = ST_IDLE;
      ST_Q_EMIT: state_nxt = ST_IDLE;
      ST_Q_LAST: state_nxt = (mem_rdata.stamp <= t_r) ? ST_IDLE : ST_Q_K;
      ST_Q_K:    state_nxt = (mem_rdata.stamp == t_r) ? ST_IDLE : ST_Q_A;
      ST_Q_A:    state_nxt = ST_LERP_GO;
      ST_LERP_GO: state_nxt = ST_LERP_WAIT;
      ST_LERP_WAIT: begin
        if (lrsp.done) begin
          state_nxt = (comp_r == COMP_W'(NCOMP - 1)) ? ST_IDLE : ST_LERP_GO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    dst_nxt       = dst_r;
    tgt_nxt       = tgt_r;
    up_nxt        = up_r;
    op_nxt        = op_r;
    t_nxt         = t_r;
    newv_nxt      = newv_r;
    a_vals_nxt    = a_vals_r;
    b_vals_nxt    = b_vals_r;
    res_nxt       = res_r;
    dt_nxt        = dt_r;
    span_nxt      = span_r;
    comp_nxt      = comp_r;
    out_valid_nxt = 1'b0;
    out_empty_nxt = out_empty_r;
    out_vals_nxt  = out_vals_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    lreq.start    = 1'b0;
    lreq.a        = a_vals_r[comp_r*VAL_W +: VAL_W];
    lreq.b        = b_vals_r[comp_r*VAL_W +: VAL_W];
    lreq.dt       = dt_r;
    lreq.span     = span_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_opcode;
          t_nxt    = in_time_stamp;
          newv_nxt = clamped;
          lo_nxt   = '0;
          hi_nxt   = count_r;
          if (in_opcode == OP_QUERY && count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_empty_nxt = 1'b1;
            out_vals_nxt  = '0;
          end
        end
      end
      ST_SRCH: begin
        mid_nxt   = mid_sum[CW:1];
        mem_re    = (lo_r < hi_r);
        mem_raddr = mid_sum[AW:1];
      end
      ST_SRCH_CMP: begin
        if (hit) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + CW'(1);
        end
      end
      ST_POST: begin
        if (op_r == OP_QUERY) begin
          mem_re    = 1'b1;
          mem_raddr = (lo_r == '0) ? '0 : AW'(count_r - CW'(1));
        end else if (count_r < CW'(HISTORY_DEPTH)) begin
          up_nxt  = 1'b1;
          dst_nxt = count_r;
          tgt_nxt = lo_r;
        end else begin
          up_nxt  = 1'b0;
          dst_nxt = '0;
          tgt_nxt = lo_r - CW'(1);
        end
      end
      ST_SH_RD: begin
        mem_re    = (dst_r != tgt_r);
        mem_raddr = src[AW-1:0];
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r[AW-1:0];
        mem_wdata = mem_rdata;
        dst_nxt   = src;
      end
      ST_INS_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = tgt_r[AW-1:0];
        mem_wdata.stamp = t_r;
        mem_wdata.vals  = newv_r;
        if (up_r) begin
          count_nxt = count_r + CW'(1);
        end
      end
      ST_Q_EMIT: begin
        out_valid_nxt = 1'b1;
        out_empty_nxt = 1'b0;
        out_vals_nxt  = mem_rdata.vals;
      end
      ST_Q_LAST: begin
        if (mem_rdata.stamp <= t_r) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = 1'b0;
          out_vals_nxt  = mem_rdata.vals;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = lo_r[AW-1:0];
        end
      end
      ST_Q_K: begin
        if (mem_rdata.stamp == t_r) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = 1'b0;
          out_vals_nxt  = mem_rdata.vals;
        end else begin
          b_vals_nxt = mem_rdata.vals;
          span_nxt   = mem_rdata.stamp;
          mem_re     = 1'b1;
          mem_raddr  = AW'(lo_r - CW'(1));
        end
      end
      ST_Q_A: begin
        a_vals_nxt = mem_rdata.vals;
        span_nxt   = span_r - mem_rdata.stamp;
        dt_nxt     = t_r - mem_rdata.stamp;
        comp_nxt   = '0;
      end
      ST_LERP_GO: begin
        lreq.start = 1'b1;
      end
      ST_LERP_WAIT: begin
        if (lrsp.done) begin
          res_nxt[comp_r*VAL_W +: VAL_W] = lrsp.value;
          comp_nxt = comp_r + COMP_W'(1);
          if (comp_r == COMP_W'(NCOMP - 1)) begin
            out_valid_nxt = 1'b1;
            out_empty_nxt = 1'b0;
            out_vals_nxt  = res_nxt;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rate_lim_r  <= RATE_LIMIT_RST;
      accel_lim_r <= ACCEL_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RATE_LIMIT) begin
          rate_lim_r <= cfg_wdata[LIM_W-1:0];
        end else if (cfg_index == REG_ACCEL_LIMIT) begin
          accel_lim_r <= cfg_wdata[LIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    dst_r       <= dst_nxt;
    tgt_r       <= tgt_nxt;
    up_r        <= up_nxt;
    op_r        <= op_nxt;
    t_r         <= t_nxt;
    newv_r      <= newv_nxt;
    a_vals_r    <= a_vals_nxt;
    b_vals_r    <= b_vals_nxt;
    res_r       <= res_nxt;
    dt_r        <= dt_nxt;
    span_r      <= span_nxt;
    comp_r      <= comp_nxt;
    out_empty_r <= out_empty_nxt;
    out_vals_r  <= out_vals_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_history_empty = out_empty_r;
  assign out_rate_x_out    = out_vals_r[0*VAL_W +: VAL_W];
  assign out_rate_y_out    = out_vals_r[1*VAL_W +: VAL_W];
  assign out_rate_z_out    = out_vals_r[2*VAL_W +: VAL_W];
  assign out_accel_x_out   = out_vals_r[3*VAL_W +: VAL_W];
  assign out_accel_y_out   = out_vals_r[4*VAL_W +: VAL_W];
  assign out_accel_z_out   = out_vals_r[5*VAL_W +: VAL_W];

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HISTORY_DEPTH)) else $error("history count overflow");
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_QUERY && count_r == '0) |=> (out_valid && out_history_empty))
    else $error("empty query not answered");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_Q_EMIT ||
                   $past(state_r) == ST_Q_LAST || $past(state_r) == ST_Q_K ||
                   $past(state_r) == ST_LERP_WAIT))
    else $error("result from unexpected state");
  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_WR && up_r) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow history");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for imu_sample_history_interpolator_unit.
// Drives inserts and queries plus limit writes, predicts each query result
// from its history model or a given expectation, checks each output strobe. Uses ishi_pkg.
module tb_top;
  import ishi_pkg::*;

  localparam int DEPTH    = 256;
  localparam int WDOG_MAX = 20000;
  localparam int SETTLE   = 600;

  typedef struct packed {
    logic [NCOMP-1:0][VAL_W-1:0] vals;
    logic                        empty;
  } sample_out_t;

  typedef struct packed {
    logic                        op;
    stamp_t                      stamp;
    logic [NCOMP-1:0][VAL_W-1:0] vals;
    logic [NCOMP-1:0]            mask;
    logic                        typed;
    sample_out_t                 want;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = OP_INSERT;
  logic [TIME_W-1:0] in_time_stamp = '0;
  logic signed [VAL_W-1:0] in_rate_x_in = '0, in_rate_y_in = '0, in_rate_z_in = '0;
  logic signed [VAL_W-1:0] in_accel_x_in = '0, in_accel_y_in = '0, in_accel_z_in = '0;
  logic [NCOMP-1:0] in_invalid_mask = '0;
  logic out_valid;
  logic signed [VAL_W-1:0] out_rate_x_out, out_rate_y_out, out_rate_z_out;
  logic signed [VAL_W-1:0] out_accel_x_out, out_accel_y_out, out_accel_z_out;
  logic out_history_empty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RATE_LIMIT;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  logic        drv_typed = 1'b0;
  sample_out_t drv_want = '0;

  always #5 clk = ~clk;

  imu_sample_history_interpolator_unit #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_time_stamp(in_time_stamp),
    .in_rate_x_in(in_rate_x_in), .in_rate_y_in(in_rate_y_in),
    .in_rate_z_in(in_rate_z_in), .in_accel_x_in(in_accel_x_in),
    .in_accel_y_in(in_accel_y_in), .in_accel_z_in(in_accel_z_in),
    .in_invalid_mask(in_invalid_mask), .out_valid(out_valid),
    .out_rate_x_out(out_rate_x_out), .out_rate_y_out(out_rate_y_out),
    .out_rate_z_out(out_rate_z_out), .out_accel_x_out(out_accel_x_out),
    .out_accel_y_out(out_accel_y_out), .out_accel_z_out(out_accel_z_out),
    .out_history_empty(out_history_empty), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // history model
  stamp_t                      hist_time[DEPTH];
  logic [NCOMP-1:0][VAL_W-1:0] hist_vals[DEPTH];
  int                          hist_count = 0;
  logic [LIM_W-1:0]            rate_lim = RATE_LIMIT_RST;
  logic [LIM_W-1:0]            accel_lim = ACCEL_LIMIT_RST;

  sample_out_t expected_q[$];
  int errors = 0;
  int n_acc = 0, n_cfg = 0, n_ins = 0, n_qry = 0, n_res = 0;
  int wdog = 0;

  function automatic logic [VAL_W-1:0] limit_comp(logic [VAL_W-1:0] x, logic [LIM_W-1:0] lim);
    longint v;
    longint l;
    v = longint'($signed(x));
    l = longint'(lim);
    if (v > l) v = l;
    if (v < -l) v = -l;
    return v[VAL_W-1:0];
  endfunction

  function automatic void hist_insert(stamp_t t, logic [NCOMP-1:0][VAL_W-1:0] raw,
                                      logic [NCOMP-1:0] mask);
    logic [NCOMP-1:0][VAL_W-1:0] v;
    int pos;
    for (int i = 0; i < NCOMP; i++) begin
      v[i] = limit_comp(mask[i] ? '0 : raw[i], (i < 3) ? rate_lim : accel_lim);
    end
    pos = 0;
    while (pos < hist_count && hist_time[pos] <= t) pos++;
    if (hist_count < DEPTH) begin
      for (int j = hist_count; j > pos; j--) begin
        hist_time[j] = hist_time[j-1];
        hist_vals[j] = hist_vals[j-1];
      end
      hist_count++;
    end else begin
      if (pos == 0) return;
      for (int j = 0; j < pos - 1; j++) begin
        hist_time[j] = hist_time[j+1];
        hist_vals[j] = hist_vals[j+1];
      end
      pos--;
    end
    hist_time[pos] = t;
    hist_vals[pos] = v;
  endfunction

  function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                             stamp_t dt, stamp_t span);
    longint d;
    logic [127:0] mag;
    logic [127:0] q;
    longint r;
    d = longint'($signed(b)) - longint'($signed(a));
    mag = (d < 0) ? 128'(-d) : 128'(d);
    q = (mag * {64'd0, dt}) / {64'd0, span};
    r = (d < 0) ? longint'($signed(a)) - longint'(q[63:0])
                : longint'($signed(a)) + longint'(q[63:0]);
    return r[VAL_W-1:0];
  endfunction

  function automatic sample_out_t hist_lookup(stamp_t t);
    sample_out_t r;
    int k;
    int last;
    r = '0;
    if (hist_count == 0) begin
      r.empty = 1'b1;
      return r;
    end
    last = hist_count - 1;
    if (t <= hist_time[0]) begin
      k = 0;
    end else if (t >= hist_time[last]) begin
      k = last;
    end else begin
      k = 1;
      while (k < last && hist_time[k] < t) k++;
      if (hist_time[k] > t) begin
        for (int i = 0; i < NCOMP; i++) begin
          r.vals[i] = blend(hist_vals[k-1][i], hist_vals[k][i], t - hist_time[k-1],
                            hist_time[k] - hist_time[k-1]);
        end
        return r;
      end
    end
    r.vals = hist_vals[k];
    return r;
  endfunction

  task automatic report(string fld, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    errors++;
    $display("mismatch on %s at result %0d: got %h want %h", fld, n_res, got, want);
  endtask

  always @(posedge clk) begin
    sample_out_t w;
    logic [NCOMP-1:0][VAL_W-1:0] got;
    string names[NCOMP];
    names = '{"rate_x", "rate_y", "rate_z", "accel_x", "accel_y", "accel_z"};
    if (rst_n) begin
      wdog++;
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        wdog = 0;
        if (cfg_index == REG_RATE_LIMIT) rate_lim = cfg_wdata[LIM_W-1:0];
        else if (cfg_index == REG_ACCEL_LIMIT) accel_lim = cfg_wdata[LIM_W-1:0];
      end
      if (start && !busy) begin
        n_acc++;
        wdog = 0;
        if (in_opcode == OP_QUERY) begin
          n_qry++;
          expected_q.push_back(drv_typed ? drv_want : hist_lookup(in_time_stamp));
        end else begin
          n_ins++;
          hist_insert(in_time_stamp, {in_accel_z_in, in_accel_y_in, in_accel_x_in,
                                      in_rate_z_in, in_rate_y_in, in_rate_x_in},
                      in_invalid_mask);
        end
      end
      if (out_valid) begin
        wdog = 0;
        got = {out_accel_z_out, out_accel_y_out, out_accel_x_out,
               out_rate_z_out, out_rate_y_out, out_rate_x_out};
        if (expected_q.size() == 0) begin
          errors++;
          $display("unexpected result at result %0d", n_res);
        end else begin
          w = expected_q.pop_front();
          for (int i = 0; i < NCOMP; i++) begin
            if (got[i] !== w.vals[i]) report(names[i], got[i], w.vals[i]);
          end
          if (out_history_empty !== w.empty)
            report("history_empty", 32'(out_history_empty), 32'(w.empty));
        end
        n_res++;
      end
      if (wdog >= WDOG_MAX) begin
        $display("watchdog expired with %0d results outstanding", expected_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic cmd_t mk_ins(stamp_t t, logic [NCOMP-1:0][VAL_W-1:0] v,
                                  logic [NCOMP-1:0] m);
    cmd_t c;
    c = '0;
    c.op = OP_INSERT;
    c.stamp = t;
    c.vals = v;
    c.mask = m;
    return c;
  endfunction

  function automatic cmd_t mk_qry(stamp_t t, logic typed = 1'b0, sample_out_t want = '0);
    cmd_t c;
    c = '0;
    c.op = OP_QUERY;
    c.stamp = t;
    c.typed = typed;
    c.want = want;
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] rnd_val();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    if (s == 1) return VAL_W'($signed($urandom_range(0, 8000)) - 4000);
    return $urandom();
  endfunction

  stamp_t tcur;

  function automatic cmd_t rnd_cmd();
    cmd_t c;
    int s;
    logic [NCOMP-1:0][VAL_W-1:0] v;
    stamp_t t;
    s = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 58) begin
      if (s < 70) begin
        tcur = tcur + $urandom_range(1, 1000);
        t = tcur;
      end else if (s < 80) t = tcur;
      else if (s < 94) t = tcur - $urandom_range(0, 300000);
      else if (s < 97) t = {$urandom(), $urandom()};
      else t = ($urandom_range(0, 1) != 0) ? '1 : '0;
      for (int i = 0; i < NCOMP; i++) v[i] = rnd_val();
      c = mk_ins(t, v, ($urandom_range(0, 9) < 7) ? '0 : NCOMP'($urandom()));
    end else begin
      if (s < 45) t = tcur - $urandom_range(0, 20000);
      else if (s < 65 && hist_count > 0) t = hist_time[$urandom_range(0, hist_count - 1)];
      else if (s < 75) t = '0;
      else if (s < 85) t = {$urandom(), $urandom()};
      else t = tcur + $urandom_range(0, 2000);
      c = mk_qry(t);
    end
    return c;
  endfunction

  task automatic send(cmd_t c, int idle_pct);
    int seen;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= c.op;
    in_time_stamp <= c.stamp;
    in_rate_x_in <= c.vals[0];
    in_rate_y_in <= c.vals[1];
    in_rate_z_in <= c.vals[2];
    in_accel_x_in <= c.vals[3];
    in_accel_y_in <= c.vals[4];
    in_accel_z_in <= c.vals[5];
    in_invalid_mask <= c.mask;
    drv_typed <= c.typed;
    drv_want <= c.want;
    seen = n_acc;
    do @(negedge clk); while (n_acc == seen);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    int seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    seen = n_cfg;
    do @(negedge clk); while (n_cfg == seen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    cmd_t tab[$];
    sample_out_t w;
    int idle_pct[4];
    logic [CFG_DAT_W-1:0] rl[4];
    logic [CFG_DAT_W-1:0] al[4];
    idle_pct = '{0, 87, 20, 0};
    rl = '{32'h0000_0000, 32'hffff_ffff, $urandom(), 32'h0001_0000};
    al = '{32'h7fff_ffff, 32'h0000_0000, $urandom(), 32'h0050_0000};

    w = '0;
    w.empty = 1'b1;
    tab.push_back(mk_qry(64'd5, 1'b1, w));
    tab.push_back(mk_ins(64'd100, {32'd1, 32'h8000_0000, 32'h7fff_ffff,
                                   32'd0, 32'h8000_0000, 32'h7fff_ffff}, 6'h00));
    w = '0;
    w.vals = {32'd1, -32'sd5242880, 32'sd5242880, 32'd0, -32'sd983040, 32'sd983040};
    tab.push_back(mk_qry(64'd0, 1'b1, w));
    tab.push_back(mk_qry(64'd100, 1'b1, w));
    tab.push_back(mk_ins(64'd200, {32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2}, 6'h3f));
    tab.push_back(mk_qry(64'd150));
    tab.push_back(mk_qry(64'd101));
    tab.push_back(mk_ins(64'd200, {32'h0004_0000, -32'sd70000, 32'h0002_0000,
                                   -32'sd1, 32'd12345, -32'sd65536}, 6'h15));
    tab.push_back(mk_qry(64'd200));
    tab.push_back(mk_qry(64'd199));
    tab.push_back(mk_qry('1));
    tab.push_back(mk_ins('1, {32'hfff0_0000, 32'h0010_0000, 32'hffff_0000,
                              32'h0000_8000, 32'h8000_0001, 32'h7fff_fffe}, 6'h2a));
    tab.push_back(mk_ins(64'd0, {32'd100, 32'd200, 32'd300,
                                 32'd400, 32'd500, 32'd600}, 6'h00));
    tab.push_back(mk_qry(64'd1));
    tab.push_back(mk_qry(64'd50));
    tab.push_back(mk_qry(64'hffff_ffff_ffff_fffe));
    tab.push_back(mk_qry(64'h8000_0000_0000_0000));
    tab.push_back(mk_qry('1));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (tab[i]) send(tab[i], 0);
    drain();

    tcur = 64'd1000;
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(REG_RATE_LIMIT, rl[ph]);
      write_limit(REG_ACCEL_LIMIT, al[ph]);
      for (int n = 0; n < 460; n++) send(rnd_cmd(), idle_pct[ph]);
      drain();
    end

    $display("ran %0d inserts and %0d queries over %0d limit writes, %0d results checked",
             n_ins, n_qry, n_cfg, n_res);
    $display("history depth at end: %0d, idle phases 0/87/20/0 percent", hist_count);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ishi_pkg.sv
rtl/ishi_mem.sv
rtl/ishi_lerp.sv
rtl/imu_sample_history_interpolator_unit.sv
tb/tb_top.sv
